[rtl/core/fssh_pkg.sv]
`default_nettype none

package fssh_pkg;

    localparam int SYM_W           = 8;
    localparam int SYMBOLS         = 1 << SYM_W;
    localparam int SLOT_W          = 8;
    localparam int FREE_W          = SLOT_W + 1;
    localparam int OUT_COUNT_W     = 32;
    localparam int COUNT_W_DEFAULT = 32;

    // lookup status of the symbol in hand, from the seen map to the control
    typedef struct packed {
        logic              seen;
        logic [SLOT_W-1:0] free_slot;
    } fssh_alloc_t;

endpackage

`default_nettype wire

[rtl/core/fssh_ram.sv]
`default_nettype none

module fssh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/fssh_seen.sv]
`default_nettype none

module fssh_seen
    import fssh_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [SYM_W-1:0] sym,
    input  wire logic             mark,
    output fssh_alloc_t           status
);

    logic [SYMBOLS-1:0] seen_reg;
    logic [FREE_W-1:0]  free_reg;
    logic [FREE_W-1:0]  free_next;

    always_comb
    begin
        free_next = free_reg;
        if (mark && !seen_reg[sym] && (free_reg < FREE_W'(SYMBOLS)))
        begin
            free_next = free_reg + FREE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            free_reg <= '0;
        end
        else
        begin
            free_reg <= free_next;
            if (mark)
            begin
                seen_reg[sym] <= 1'b1;
            end
        end
    end

    assign status.seen      = seen_reg[sym];
    assign status.free_slot = free_reg[SLOT_W-1:0];

endmodule

`default_nettype wire

[rtl/core/first_seen_symbol_histogram.sv]
// First-seen symbol histogram: counts byte symbols and numbers each distinct
// symbol in the order of its first appearance.
// Input channel: in_valid / in_stall carry one symbol per request. Output
// channel: out_valid / out_stall carry slot, count and first_seen, one
// result per accepted symbol, in input order.
// An accepted symbol is registered and looked up in ST_LOOK; its result is
// loaded into the output register and shown at out_valid once that is free.
// Each symbol is a read-modify-write of the symbol-indexed entry RAM, whose
// read data is registered; the input is stalled while in ST_LOOK, so no new
// symbol is taken before the last one has left the lookup state.
// When the receiver stalls with a result still held, the next symbol is still
// taken and looked up, then held in the lookup stage until the output frees.
// Reset clears the seen map, the free-slot counter, the control state and the
// output valid. RAM contents are not cleared: an entry's read data is used only
// for a symbol that has been seen, so it was written before.
// Counts saturate at 2^COUNT_WIDTH - 1; the count port carries the low 32
// bits of the count.
`default_nettype none

module first_seen_symbol_histogram
    import fssh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_W_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SYM_W-1:0]       symbol,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [SLOT_W-1:0]      slot,
    output logic      [OUT_COUNT_W-1:0] count,
    output logic                        first_seen
);

    localparam int ENTRY_W = SLOT_W + COUNT_WIDTH;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t                  state_reg;
    logic [SYM_W-1:0]        sym_reg;
    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [OUT_COUNT_W-1:0]  count_reg;
    logic                    first_reg;

    logic                    accept;
    logic                    commit;
    logic [ENTRY_W-1:0]      rd_entry;
    logic [ENTRY_W-1:0]      wr_entry;
    logic [SLOT_W-1:0]       slot_next;
    logic [COUNT_WIDTH-1:0]  cnt_old;
    logic [COUNT_WIDTH-1:0]  cnt_next;
    fssh_alloc_t             alloc;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    // commit the update once the output register can take the result
    assign commit   = (state_reg == ST_LOOK) && (!out_valid_reg || !out_stall);

    // entry per symbol: slot in the upper bits, count below
    fssh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOLS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (sym_reg),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (symbol),
        .rdata (rd_entry)
    );

    fssh_seen u_seen (
        .clk    (clk),
        .rst_n  (rst_n),
        .sym    (sym_reg),
        .mark   (commit),
        .status (alloc)
    );

    assign cnt_old = rd_entry[COUNT_WIDTH-1:0];

    always_comb
    begin
        if (alloc.seen)
        begin
            slot_next = rd_entry[ENTRY_W-1:COUNT_WIDTH];
            // saturate at all ones
            cnt_next  = (&cnt_old) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
        end
        else
        begin
            slot_next = alloc.free_slot;
            cnt_next  = COUNT_WIDTH'(1);
        end
    end

    assign wr_entry = {slot_next, cnt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sym_reg       <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b0;
        end
        else
        begin
            // drop the result once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sym_reg   <= symbol;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    // hold the looked-up entry until the output frees
                    if (commit)
                    begin
                        slot_reg      <= slot_next;
                        count_reg     <= OUT_COUNT_W'(cnt_next);
                        first_reg     <= !alloc.seen;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot       = slot_reg;
    assign count      = count_reg;
    assign first_seen = first_reg;

`ifndef SYNTHESIS
    // a symbol taken must be followed by its lookup cycle
    a_accept_then_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOK))
        else $error("accepted symbol did not enter lookup");

    // a new symbol always starts its count at one
    a_first_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_seen) |-> (count == OUT_COUNT_W'(1)))
        else $error("first-seen result with count other than one");

    // a result is loaded only by a commit, and a commit always loads one
    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid && (state_reg == ST_IDLE)))
        else $error("commit did not present a result");
`endif

endmodule

`default_nettype wire

[sim/first_seen_symbol_histogram_tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the first-seen symbol histogram.
// A behavioural copy of the table predicts slot, count and first_seen for every
// accepted request. A monitor compares each result leaving the block against
// the oldest prediction. The bench runs the block at its default count width.
module first_seen_symbol_histogram_tb;

    import fssh_pkg::*;

    localparam int TALLY_W      = COUNT_W_DEFAULT;
    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef struct packed {
        logic [SLOT_W-1:0]      slot;
        logic [OUT_COUNT_W-1:0] count;
        logic                   first_seen;
    } tally_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [SYM_W-1:0]       symbol    = '0;
    logic                   out_stall = 1'b0;
    logic                   in_stall;
    logic                   out_valid;
    logic [SLOT_W-1:0]      slot;
    logic [OUT_COUNT_W-1:0] count;
    logic                   first_seen;

    // Behavioural copy of the histogram table.
    logic               symbol_seen [SYMBOLS] = '{default: 1'b0};
    logic [SLOT_W-1:0]  slot_of     [SYMBOLS];
    logic [TALLY_W-1:0] slot_tally  [SYMBOLS];
    logic [FREE_W-1:0]  next_slot   = '0;

    // Predicted results in arrival order.
    tally_result_t pending_results [$];
    tally_result_t oldest_result;

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int error_count     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int saturated_hits  = 0;
    int cycle_count     = 0;

    first_seen_symbol_histogram #(
        .COUNT_WIDTH (TALLY_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .symbol     (symbol),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot       (slot),
        .count      (count),
        .first_seen (first_seen)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Receiver back-pressure: roll a fresh stall decision every cycle, so that
    // stalls land on both the lookup and the output phase of the block.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: abandon the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Work out what the block must report for one accepted symbol and update
    // the copy of the table. A new symbol takes the next free slot with count
    // one; a known symbol bumps the count of its slot and holds at the ceiling.
    function automatic tally_result_t predict_symbol(input logic [SYM_W-1:0] sym);
        tally_result_t     res;
        logic [SLOT_W-1:0] s;
        if (symbol_seen[sym])
        begin
            s = slot_of[sym];
            if (slot_tally[s] != TALLY_MAX)
                slot_tally[s] = slot_tally[s] + 1'b1;
            else
                saturated_hits++;
            res.first_seen = 1'b0;
        end
        else
        begin
            s                = next_slot[SLOT_W-1:0];
            symbol_seen[sym] = 1'b1;
            slot_of[sym]     = s;
            slot_tally[s]    = TALLY_W'(1);
            if (next_slot < SYMBOLS)
                next_slot = next_slot + 1'b1;
            res.first_seen = 1'b1;
        end
        res.slot  = s;
        res.count = OUT_COUNT_W'(slot_tally[s]);
        return res;
    endfunction

    // Send one request. Idle gaps drop valid and put noise on the symbol bus;
    // once valid is raised, hold the payload until the block takes it.
    task automatic send_symbol(input logic [SYM_W-1:0] sym);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            symbol   <= SYM_W'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.insert(pending_results.size(), predict_symbol(sym));
        requests_sent++;
    endtask

    task automatic set_idling(input int idle_in, input int stall_in);
        send_idle_pct = idle_in;
        stall_pct     = stall_in;
    endtask

    // Field extremes, first sightings and back-to-back repeats of one symbol,
    // which exercise the read-after-write interlock.
    task automatic test_first_and_repeat();
        logic [SYM_W-1:0] picks [16] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h80,
                                         8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h80,
                                         8'h00, 8'h7F, 8'hAA, 8'h55};
        set_idling(0, 0);
        foreach (picks[i])
            send_symbol(picks[i]);
    endtask

    // Hammer one symbol with the receiver stalling, so that the held result
    // and the pending lookup overlap.
    task automatic test_repeat_under_stall();
        set_idling(0, 62);
        for (int i = 0; i < 40; i++)
            send_symbol(8'h3C);
    endtask

    // Mostly a hot symbol and immediate repeats, the rest uniform, so that
    // counts climb and same-entry hazards are frequent.
    task automatic test_random_traffic(input int n_items, input int idle_in,
                                       input int stall_in);
        logic [SYM_W-1:0] hot;
        logic [SYM_W-1:0] prev;
        logic [SYM_W-1:0] sym;
        int               roll;
        set_idling(idle_in, stall_in);
        hot  = SYM_W'($urandom);
        prev = SYM_W'($urandom);
        for (int i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                sym = prev;
            else if (roll < 55)
                sym = hot;
            else
                sym = SYM_W'($urandom);
            send_symbol(sym);
            prev = sym;
        end
    endtask

    // Present every symbol value once in shuffled order, so the table fills
    // up to its last slot and every symbol bit toggles both ways.
    task automatic test_fill_table();
        logic [SYM_W-1:0] order [SYMBOLS];
        logic [SYM_W-1:0] swap;
        int               j;
        set_idling(37, 37);
        foreach (order[i])
            order[i] = SYM_W'(i);
        for (int i = SYMBOLS - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        foreach (order[i])
            send_symbol(order[i]);
    endtask

    // Result monitor: take each accepted result and compare it field by field
    // with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result slot %0d count %0d first_seen %0b",
                         $time, slot, count, first_seen);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (slot !== oldest_result.slot)
                begin
                    error_count++;
                    $display("%0t: slot mismatch, expected %0d actual %0d",
                             $time, oldest_result.slot, slot);
                end
                if (count !== oldest_result.count)
                begin
                    error_count++;
                    $display("%0t: count mismatch, expected %0d actual %0d",
                             $time, oldest_result.count, count);
                end
                if (first_seen !== oldest_result.first_seen)
                begin
                    error_count++;
                    $display("%0t: first_seen mismatch, expected %0b actual %0b",
                             $time, oldest_result.first_seen, first_seen);
                end
            end
        end
    end

    initial
    begin
        // Hold reset at start, then release it on a clock edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_and_repeat();
        test_repeat_under_stall();
        test_random_traffic(75, 0, 0);
        test_random_traffic(75, 62, 0);
        test_random_traffic(75, 0, 62);
        test_fill_table();
        test_random_traffic(75, 37, 37);

        // Drop valid after the last request, then drain the outstanding results
        // and keep watching the output for any stray result.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results, %0d distinct symbols placed,",
                 requests_sent, results_checked, next_slot);
        $display("%0d increments held at the %0d-bit ceiling, %0d mismatches",
                 saturated_hits, TALLY_W, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
rtl/core/fssh_pkg.sv
rtl/core/fssh_ram.sv
rtl/core/fssh_seen.sv
rtl/core/first_seen_symbol_histogram.sv
sim/first_seen_symbol_histogram_tb.sv
